/* hdl/ptt_pkg.sv */
// Package for the periodic timer table: beat types, the stored timer record,
// command and status codes, and the request and response of the shared adder.
// No dependencies.
`default_nettype none

package ptt_pkg;

  localparam int unsigned TIME_W = 48;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EXPIRED  = 3'd4,
    ST_NONE     = 3'd5
  } status_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] duration;
    logic        periodic;
    logic [7:0]  handle;
    logic [15:0] elapsed;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] expired_handle;
    logic       last;
  } out_t;

  typedef struct packed {
    logic              periodic;
    logic [31:0]       duration;
    logic [TIME_W-1:0] deadline;
    logic [7:0]        handle;
  } rec_t;

  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [31:0]       b;
    logic [TIME_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              le;
  } alu_rsp_t;

endpackage

`default_nettype wire

/* hdl/ptt_alu.sv */
// Shared time unit: saturating add of a duration to the current time and
// the deadline compare against it. Depends on ptt_pkg.
`default_nettype none

module ptt_alu (
  input  ptt_pkg::alu_req_t req_i,
  output ptt_pkg::alu_rsp_t rsp_o
);

  logic [ptt_pkg::TIME_W:0] sum_full;

  assign sum_full = {1'b0, req_i.a} + {{(ptt_pkg::TIME_W - 31){1'b0}}, req_i.b};

  assign rsp_o.sum = sum_full[ptt_pkg::TIME_W] ? {ptt_pkg::TIME_W{1'b1}}
                                               : sum_full[ptt_pkg::TIME_W-1:0];
  assign rsp_o.le  = (req_i.c <= req_i.a);

endmodule

`default_nettype wire

/* hdl/ptt_store.sv */
// Timer record memory: one write port and one read port with registered
// read data. Depends on ptt_pkg.
`default_nettype none

module ptt_store #(
  parameter int unsigned SLOTS = 16
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [$clog2(SLOTS)-1:0]  waddr_i,
  input  ptt_pkg::rec_t             wdata_i,
  input  wire                       re_i,
  input  wire  [$clog2(SLOTS)-1:0]  raddr_i,
  output ptt_pkg::rec_t             rdata_o
);

  ptt_pkg::rec_t mem_q [SLOTS];
  ptt_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/ptt_ctrl.sv */
// Timer table sequencer: walks the table at most once per item, compacting
// them on remove and tick; drives the shared time unit. Depends on ptt_pkg.
`default_nettype none

module ptt_ctrl #(
  parameter int unsigned SLOTS = 16
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  ptt_pkg::in_t              in_data_i,
  input  wire                       push_ok_i,
  output logic                      push_valid_o,
  output ptt_pkg::out_t             push_data_o,
  output ptt_pkg::alu_req_t         alu_req_o,
  input  ptt_pkg::alu_rsp_t         alu_rsp_i,
  output logic                      mem_we_o,
  output logic [$clog2(SLOTS)-1:0]  mem_waddr_o,
  output ptt_pkg::rec_t             mem_wdata_o,
  output logic                      mem_re_o,
  output logic [$clog2(SLOTS)-1:0]  mem_raddr_o,
  input  ptt_pkg::rec_t             mem_rdata_i
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_WALK,
    S_RES
  } state_e;

  state_e                    state_q, state_d;
  ptt_pkg::in_t              item_q, item_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic [CW-1:0]             wr_q, wr_d;
  logic                      found_q, found_d;
  logic                      pend_valid_q, pend_valid_d;
  logic [7:0]                pend_handle_q, pend_handle_d;
  logic [ptt_pkg::TIME_W-1:0] now_q, now_d;
  ptt_pkg::rec_t             carry_q, carry_d;
  ptt_pkg::out_t             res_q, res_d;
  logic                      advance;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    wr_d          = wr_q;
    found_d       = found_q;
    pend_valid_d  = pend_valid_q;
    pend_handle_d = pend_handle_q;
    now_d         = now_q;
    carry_d       = carry_q;
    res_d         = res_q;
    advance       = 1'b0;
    push_valid_o  = 1'b0;
    push_data_o   = '0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = wr_q[AW-1:0];
    mem_wdata_o   = mem_rdata_i;
    mem_re_o      = 1'b0;
    mem_raddr_o   = '0;
    alu_req_o.a   = now_q;
    alu_req_o.b   = mem_rdata_i.duration;
    alu_req_o.c   = mem_rdata_i.deadline;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        idx_d        = '0;
        wr_d         = '0;
        found_d      = 1'b0;
        pend_valid_d = 1'b0;
        mem_re_o     = (cnt_q != '0);
        state_d      = S_WALK;
        case (item_q.command)
          ptt_pkg::CMD_ADD: begin
            alu_req_o.b = item_q.duration;
            if (cnt_q == SlotsC) begin
              res_d   = '{status: ptt_pkg::ST_FULL, expired_handle: 8'd0, last: 1'b1};
              state_d = S_RES;
            end else begin
              carry_d = '{periodic: item_q.periodic, duration: item_q.duration,
                          deadline: alu_rsp_i.sum, handle: item_q.handle};
            end
          end
          ptt_pkg::CMD_REMOVE: begin
          end
          ptt_pkg::CMD_TICK: begin
            alu_req_o.b = {16'd0, item_q.elapsed};
            now_d       = alu_rsp_i.sum;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        if (idx_q == cnt_q) begin
          state_d = S_RES;
          case (item_q.command)
            ptt_pkg::CMD_ADD: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = cnt_q[AW-1:0];
              mem_wdata_o = carry_q;
              cnt_d       = cnt_q + CW'(1);
              res_d       = '{status: ptt_pkg::ST_ADDED, expired_handle: 8'd0, last: 1'b1};
            end
            ptt_pkg::CMD_REMOVE: begin
              if (found_q) begin
                cnt_d = cnt_q - CW'(1);
                res_d = '{status: ptt_pkg::ST_REMOVED, expired_handle: 8'd0, last: 1'b1};
              end else begin
                res_d = '{status: ptt_pkg::ST_NOTFOUND, expired_handle: 8'd0, last: 1'b1};
              end
            end
            ptt_pkg::CMD_TICK: begin
              cnt_d = wr_q;
              if (pend_valid_q) begin
                res_d = '{status: ptt_pkg::ST_EXPIRED, expired_handle: pend_handle_q,
                          last: 1'b1};
              end else begin
                res_d = '{status: ptt_pkg::ST_NONE, expired_handle: 8'd0, last: 1'b1};
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end else begin
          advance = 1'b1;
          case (item_q.command)
            ptt_pkg::CMD_ADD: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = idx_q[AW-1:0];
              mem_wdata_o = carry_q;
              carry_d     = mem_rdata_i;
            end
            ptt_pkg::CMD_REMOVE: begin
              if (!found_q && (mem_rdata_i.handle == item_q.handle)) begin
                found_d = 1'b1;
              end else begin
                mem_we_o = 1'b1;
                wr_d     = wr_q + CW'(1);
              end
            end
            ptt_pkg::CMD_TICK: begin
              if (alu_rsp_i.le) begin
                if (pend_valid_q) begin
                  push_valid_o = push_ok_i;
                  push_data_o  = '{status: ptt_pkg::ST_EXPIRED,
                                   expired_handle: pend_handle_q, last: 1'b0};
                  advance      = push_ok_i;
                end
                if (advance) begin
                  pend_valid_d  = 1'b1;
                  pend_handle_d = mem_rdata_i.handle;
                  if (mem_rdata_i.periodic) begin
                    mem_we_o             = 1'b1;
                    mem_wdata_o.deadline = alu_rsp_i.sum;
                    wr_d                 = wr_q + CW'(1);
                  end
                end
              end else begin
                mem_we_o = 1'b1;
                wr_d     = wr_q + CW'(1);
              end
            end
            default: begin
              advance = 1'b0;
              state_d = S_IDLE;
            end
          endcase
          if (advance) begin
            idx_d       = idx_q + CW'(1);
            mem_re_o    = ((idx_q + CW'(1)) < cnt_q);
            mem_raddr_o = AW'(idx_q + CW'(1));
          end
        end
      end
      S_RES: begin
        push_valid_o = push_ok_i;
        push_data_o  = res_q;
        if (push_ok_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      item_q        <= '0;
      cnt_q         <= '0;
      idx_q         <= '0;
      wr_q          <= '0;
      found_q       <= 1'b0;
      pend_valid_q  <= 1'b0;
      pend_handle_q <= '0;
      now_q         <= '0;
      carry_q       <= '0;
      res_q         <= '0;
    end else begin
      state_q       <= state_d;
      item_q        <= item_d;
      cnt_q         <= cnt_d;
      idx_q         <= idx_d;
      wr_q          <= wr_d;
      found_q       <= found_d;
      pend_valid_q  <= pend_valid_d;
      pend_handle_q <= pend_handle_d;
      now_q         <= now_d;
      carry_q       <= carry_d;
      res_q         <= res_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/periodic_timer_table.sv */
// A known command's final result is written into the output register from the result
// state after its walk (at once for an add to a full table); the next item is taken only
// once that result has been written. The walk visits one stored timer per cycle through
// a single memory read port, except while a tick waits to push an expiry beat.
// Reset clears the time, the timer count and the sequencer; memory is not cleared.
// Top level of the timer table; depends on ptt_pkg, ptt_alu, ptt_store, ptt_ctrl.
`default_nettype none

module periodic_timer_table #(
  parameter int unsigned SLOTS = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  ptt_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output ptt_pkg::out_t  out_data_o
);

  localparam int unsigned AW = $clog2(SLOTS);

  ptt_pkg::alu_req_t alu_req;
  ptt_pkg::alu_rsp_t alu_rsp;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  ptt_pkg::rec_t     mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  ptt_pkg::rec_t     mem_rdata;
  logic              push_ok;
  logic              push_valid;
  ptt_pkg::out_t     push_data;
  logic              out_valid_q;
  ptt_pkg::out_t     out_q;

  ptt_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  ptt_store #(.SLOTS(SLOTS)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ptt_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_ok_i    (push_ok),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .alu_req_o    (alu_req),
    .alu_rsp_i    (alu_rsp),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // The output register takes a new beat whenever it is empty or being drained.
  assign push_ok = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (push_valid) begin
      out_valid_q <= 1'b1;
      out_q       <= push_data;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hdl/ptt_checker.sv */
// Port-level checks for the timer table and the bind that attaches them.
// Depends on ptt_pkg and periodic_timer_table.
`default_nettype none

module ptt_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_ready_o,
  input wire            out_valid_o,
  input wire            out_ready_i,
  input ptt_pkg::out_t  out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Output beat changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Block ready again straight after taking a beat.");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ptt_pkg::ST_EXPIRED)
      |-> out_data_o.last && (out_data_o.expired_handle == 8'd0))
    else $error("Non-expiry result is not a lone final beat.");

  a_ready_quiet_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("Block went busy without an input beat.");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* tb/tb_periodic_timer_table.sv */
// Self-checking testbench for the periodic timer table: a scoreboard class predicts every
// result beat from the accepted input beats; tasks drive the input channel and an
// initial block drives the output ready. Depends on ptt_pkg and periodic_timer_table.
`timescale 1ns / 100ps

module tb_periodic_timer_table;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned RANDOM_BEATS = 370;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 4 * (SLOTS + 3);
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  class timer_scoreboard;
    logic [ptt_pkg::TIME_W-1:0] clock_ms;
    ptt_pkg::rec_t              timers[$];
    ptt_pkg::out_t              outcome_q[$];
    int unsigned                mismatches;

    function new();
      clock_ms   = '0;
      mismatches = 0;
    endfunction

    function logic [ptt_pkg::TIME_W-1:0] sat_sum(logic [ptt_pkg::TIME_W-1:0] a,
                                                 logic [31:0] b);
      logic [ptt_pkg::TIME_W:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[ptt_pkg::TIME_W] ? {ptt_pkg::TIME_W{1'b1}} : s[ptt_pkg::TIME_W-1:0];
    endfunction

    function ptt_pkg::out_t outcome(ptt_pkg::status_e st, logic [7:0] hnd, logic lst);
      ptt_pkg::out_t o;
      o.status         = st;
      o.expired_handle = hnd;
      o.last           = lst;
      return o;
    endfunction

    function int unsigned stored();
      return timers.size();
    endfunction

    function int unsigned outstanding();
      return outcome_q.size();
    endfunction

    function logic [7:0] any_handle();
      if (timers.size() == 0) return 8'($urandom_range(0, 255));
      return timers[$urandom_range(0, timers.size() - 1)].handle;
    endfunction

    function void note_beat(ptt_pkg::in_t it);
      ptt_pkg::rec_t r;
      int unsigned   i;
      int unsigned   n;
      int unsigned   k;
      bit            found;
      case (it.command)
        ptt_pkg::CMD_ADD: begin
          if (timers.size() >= SLOTS) begin
            outcome_q.push_back(outcome(ptt_pkg::ST_FULL, 8'd0, 1'b1));
          end else begin
            r.periodic = it.periodic;
            r.duration = it.duration;
            r.deadline = sat_sum(clock_ms, it.duration);
            r.handle   = it.handle;
            timers.push_front(r);
            outcome_q.push_back(outcome(ptt_pkg::ST_ADDED, 8'd0, 1'b1));
          end
        end
        ptt_pkg::CMD_REMOVE: begin
          found = 1'b0;
          for (i = 0; i < timers.size() && !found; i++) begin
            if (timers[i].handle == it.handle) begin
              timers.delete(i);
              found = 1'b1;
            end
          end
          outcome_q.push_back(outcome(found ? ptt_pkg::ST_REMOVED : ptt_pkg::ST_NOTFOUND,
                                      8'd0, 1'b1));
        end
        ptt_pkg::CMD_TICK: begin
          clock_ms = sat_sum(clock_ms, {16'd0, it.elapsed});
          n = 0;
          foreach (timers[j]) if (timers[j].deadline <= clock_ms) n++;
          if (n == 0) begin
            outcome_q.push_back(outcome(ptt_pkg::ST_NONE, 8'd0, 1'b1));
          end else begin
            i = 0;
            k = 0;
            while (i < timers.size()) begin
              r = timers[i];
              if (r.deadline <= clock_ms) begin
                outcome_q.push_back(outcome(ptt_pkg::ST_EXPIRED, r.handle, k == n - 1));
                k++;
                if (r.periodic) begin
                  r.deadline = sat_sum(clock_ms, r.duration);
                  timers[i]  = r;
                  i++;
                end else begin
                  timers.delete(i);
                end
              end else begin
                i++;
              end
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_beat(ptt_pkg::out_t got);
      ptt_pkg::out_t want;
      if (outcome_q.size() == 0) begin
        $error("result beat with nothing expected: status %0d, expired_handle %0d, last %0d",
               got.status, got.expired_handle, got.last);
        mismatches++;
        return;
      end
      want = outcome_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.expired_handle !== want.expired_handle) begin
        $error("expired_handle: expected %0d, actual %0d", want.expired_handle,
               got.expired_handle);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  ptt_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  ptt_pkg::out_t out_data;

  timer_scoreboard sb = new();
  bit              calm;
  bit              hold_long;
  int unsigned     random_beats;

  periodic_timer_table #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #6 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic ptt_pkg::in_t make_beat(ptt_pkg::cmd_e c);
    ptt_pkg::in_t it;
    it.command  = c;
    it.duration = $urandom;
    it.periodic = 1'($urandom_range(0, 1));
    it.handle   = 8'($urandom_range(0, 255));
    it.elapsed  = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic offer(input ptt_pkg::in_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(it);
    if (it.command != ptt_pkg::cmd_e'(CMD_UNUSED)) random_beats++;
  endtask

  task automatic offer_add(input logic [31:0] dur, input logic per, input logic [7:0] hnd);
    ptt_pkg::in_t it;
    it          = make_beat(ptt_pkg::CMD_ADD);
    it.duration = dur;
    it.periodic = per;
    it.handle   = hnd;
    offer(it);
  endtask

  task automatic offer_remove(input logic [7:0] hnd);
    ptt_pkg::in_t it;
    it        = make_beat(ptt_pkg::CMD_REMOVE);
    it.handle = hnd;
    offer(it);
  endtask

  task automatic offer_tick(input logic [15:0] el);
    ptt_pkg::in_t it;
    it         = make_beat(ptt_pkg::CMD_TICK);
    it.elapsed = el;
    offer(it);
  endtask

  function automatic logic [31:0] pick_duration();
    if ($urandom_range(0, 19) == 0) return $urandom;
    return $urandom_range(0, 300);
  endfunction

  function automatic logic [7:0] pick_handle();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_beat(out_data);
  end

  initial begin
    int unsigned gap;
    int unsigned held;
    out_ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_long = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (calm ? 1 : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    ptt_pkg::in_t it;
    int unsigned  sel;
    int unsigned  reps;
    bit           hold_done;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    calm      = 1'b0;
    hold_long = 1'b0;
    hold_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_tick(16'd0);
    offer_remove(8'h00);
    offer_add(32'd0, 1'b0, 8'hFF);
    offer_tick(16'd0);
    offer_add(32'd5, 1'b1, 8'h01);
    offer_add(32'hFFFF_FFFF, 1'b0, 8'h00);
    offer_add(32'd5, 1'b0, 8'h01);
    offer_tick(16'd4);
    offer_tick(16'd1);
    offer_remove(8'h01);
    offer_remove(8'h01);
    offer_tick(16'hFFFF);
    it = make_beat(ptt_pkg::cmd_e'(CMD_UNUSED));
    offer(it);
    offer_add(32'd3, 1'b1, 8'hAA);
    offer_add(32'd3, 1'b1, 8'hAA);
    offer_tick(16'd3);
    offer_remove(8'hAA);
    offer_remove(8'h00);
    offer_tick(16'd3);
    offer_remove(8'hAA);

    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      if (!hold_done && random_beats >= 100) begin
        hold_long = 1'b1;
        hold_done = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        reps = $urandom_range(0, 9);
        if (reps < 5) begin
          offer_add(pick_duration(), 1'($urandom_range(0, 1)), pick_handle());
        end else if (reps < 7) begin
          offer_remove($urandom_range(0, 3) != 0 ? sb.any_handle() : pick_handle());
        end else begin
          offer_tick($urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(0, 100)));
        end
      end else if (sel < 65) begin
        while (sb.stored() < SLOTS) begin
          offer_add($urandom_range(0, 3), 1'($urandom_range(0, 1)), pick_handle());
        end
        offer_add(pick_duration(), 1'($urandom_range(0, 1)), pick_handle());
        offer_tick(16'($urandom_range(2, 10)));
      end else if (sel < 80) begin
        reps = $urandom_range(1, 6);
        repeat (reps) offer_remove(sb.any_handle());
        offer_remove(pick_handle());
      end else if (sel < 90) begin
        reps = $urandom_range(2, 6);
        repeat (reps) offer_tick(16'($urandom_range(0, 60)));
      end else if (sel < 95) begin
        it = make_beat(ptt_pkg::cmd_e'(CMD_UNUSED));
        offer(it);
      end else if (sel < 98) begin
        offer_add($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, 1'($urandom_range(0, 1)),
                  $urandom_range(0, 1) ? 8'hFF : 8'h00);
      end else begin
        offer_tick(16'hFFFF);
      end
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(15_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
